// ===== rtl/core/dmac_pkg.sv =====
// Package for the moving-average crossover trader: payload structs, register
// indexes, action and relation codes and shared constants. No dependencies.
`timescale 1ns / 1ps
package dmac_pkg;

   localparam int ShortDepthDefault = 64;
   localparam int LongDepthDefault  = 256;

   localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] RegShortWindow  = 3'd0;
   localparam logic [2:0] RegLongWindow   = 3'd1;
   localparam logic [2:0] RegFirstYear    = 3'd2;
   localparam logic [2:0] RegLastYear     = 3'd3;
   localparam logic [2:0] RegStartingCash = 3'd4;

   localparam logic [1:0] ActNone = 2'd0;
   localparam logic [1:0] ActBuy  = 2'd1;
   localparam logic [1:0] ActSell = 2'd2;

   localparam logic [1:0] RelEqual = 2'd0;
   localparam logic [1:0] RelAbove = 2'd1;
   localparam logic [1:0] RelBelow = 2'd2;

   typedef struct packed {
      logic [13:0] price_year;
      logic [31:0] close_price;
   } req_type;

   typedef struct packed {
      logic [47:0] portfolio_value;
      logic [1:0]  trade_action;
      logic [15:0] trade_total;
      logic        averages_ready;
   } rsp_type;

   // Requests to the shared divider and its completion.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/dmac_divider.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on dmac_pkg.
`timescale 1ns / 1ps
module dmac_divider
   import dmac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]};
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = 32'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/core/dmac_ring.sv =====
// One sliding window: ring memory, fill count, slot pointer and running sum.
// Depends on dmac_pkg.
`timescale 1ns / 1ps
module dmac_ring
   import dmac_pkg::*;
#(
   parameter int Depth = ShortDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic [$clog2(Depth+1)-1:0]    window,
   input  logic                          rd_go,
   input  logic                          wr_go,
   input  logic [31:0]                   price,
   output logic [$clog2(Depth+1)+31:0]   sum,
   output logic                          full
);

   localparam int AW = $clog2(Depth);
   localparam int FW = $clog2(Depth + 1);
   localparam int SW = FW + 32;

   logic [31:0]   mem [Depth];
   logic [31:0]   old_ff;
   logic [AW-1:0] slot_ff, slot_in, slot_use;
   logic [FW-1:0] fill_ff, fill_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          drop;

   // A window change may leave the slot beyond the window; wrap it first.
   assign slot_use = (FW'(slot_ff) >= window) ? '0 : slot_ff;
   assign drop     = fill_ff >= window;

   always_ff @(posedge clock) begin
      if (rd_go) old_ff <= mem[slot_use];
      if (wr_go) mem[slot_use] <= price;
   end

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (clear) begin
         slot_in = '0;
         fill_in = '0;
         sum_in  = '0;
      end else if (wr_go) begin
         if (drop) begin
            sum_in  = sum_ff - {{FW{1'b0}}, old_ff} + {{FW{1'b0}}, price};
            fill_in = window;
         end else begin
            sum_in  = sum_ff + {{FW{1'b0}}, price};
            fill_in = fill_ff + 1'b1;
         end
         if (FW'(slot_use) + FW'(1) >= window)
            slot_in = '0;
         else
            slot_in = slot_use + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   assign sum  = sum_ff;
   assign full = fill_ff >= window;

endmodule

// ===== rtl/core/dual_moving_average_crossover_trader_unit.sv =====
// Top level of the moving-average crossover trader: registers, sequencer,
// shared multiplier step and divider. Uses dmac_pkg, dmac_ring, dmac_divider.
//
// Usage: one closing price item enters on the req_ channel (valid/stall);
// the csr_ port writes the five registers; the user must write it only
// while idle, which the block itself does not enforce. Items whose year
// is outside [first_year, last_year] are dropped with no result, and the
// input stays ready for the next item. Every in-range item pushes its
// price into both windows and yields exactly one rsp_ item.
// Sequence: ring read, push, sum load, two three-step products on the one
// 32x32 multiplier, the decision (skipped while the windows are still
// filling) and a two-step share value. A golden-cross buy adds the
// one-bit-per-cycle divider forming floor((cash << 16) / price). The next
// item is taken only once the sequencer is back in idle. The result waits
// in an output register. While rsp_stall is high the next item is still
// accepted and runs up to its result, which then holds and keeps req_stall
// high. Reset loads the register reset values and empties both windows;
// ring entries are used only after being written.
`timescale 1ns / 1ps
module dual_moving_average_crossover_trader_unit
   import dmac_pkg::*;
#(
   parameter int SHORT_DEPTH = ShortDepthDefault,
   parameter int LONG_DEPTH  = LongDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam int SFW = $clog2(SHORT_DEPTH + 1);
   localparam int LFW = $clog2(LONG_DEPTH + 1);

   typedef enum logic [10:0] {
      StIdle   = 11'b00000000001,
      StRead   = 11'b00000000010,
      StPush   = 11'b00000000100,
      StLoad   = 11'b00000001000,
      StMulL   = 11'b00000010000,
      StMulR   = 11'b00000100000,
      StDecide = 11'b00001000000,
      StDiv    = 11'b00010000000,
      StSell   = 11'b00100000000,
      StValue  = 11'b01000000000,
      StOut    = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;

   logic [6:0]  short_window_ff;
   logic [8:0]  long_window_ff;
   logic [13:0] first_year_ff, last_year_ff;
   logic [47:0] starting_cash_ff;

   logic [47:0] cash_ff, cash_in;
   logic [47:0] shares_ff, shares_in;
   logic [15:0] trades_ff, trades_in;
   logic [1:0]  prior_rel_ff, prior_rel_in;
   logic        prior_valid_ff, prior_valid_in;

   logic [31:0] price_ff;
   logic [1:0]  action_ff, action_in;
   logic        ready_ff, ready_in;
   logic [79:0] left_ff, left_in;
   logic [79:0] acc_ff, acc_in;
   logic [79:0] left_keep_ff;
   logic [2:0]  step_ff, step_in;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [SFW-1:0]    sw_eff;
   logic [LFW-1:0]    lw_eff;
   logic [SFW+31:0]   short_sum;
   logic [LFW+31:0]   long_sum;
   logic              short_full, long_full;
   logic              in_range, accept;
   logic              clr_short, clr_long;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [79:0] mul_sum;
   logic [2:0]  last_step;

   logic [1:0]  rel;
   logic [79:0] prod_sh;     // product of accumulator, shifted down by 16
   logic [47:0] q_sat;
   logic [48:0] add_tmp;
   logic [47:0] prod48;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // Effective windows: zero acts as one, large values clamp to the depth.
   always_comb begin
      if (short_window_ff == '0) sw_eff = SFW'(1);
      else if (32'(short_window_ff) > SHORT_DEPTH) sw_eff = SFW'(SHORT_DEPTH);
      else sw_eff = SFW'(short_window_ff);
      if (long_window_ff == '0) lw_eff = LFW'(1);
      else if (32'(long_window_ff) > LONG_DEPTH) lw_eff = LFW'(LONG_DEPTH);
      else lw_eff = LFW'(long_window_ff);
   end

   assign clr_short = csr_write && csr_index == RegShortWindow;
   assign clr_long  = csr_write && csr_index == RegLongWindow;

   dmac_ring #(.Depth(SHORT_DEPTH)) u_short (
      .clock(clock), .reset(reset), .clear(clr_short), .window(sw_eff),
      .rd_go(state_ff == StRead), .wr_go(state_ff == StPush),
      .price(price_ff), .sum(short_sum), .full(short_full)
   );

   dmac_ring #(.Depth(LONG_DEPTH)) u_long (
      .clock(clock), .reset(reset), .clear(clr_long), .window(lw_eff),
      .rd_go(state_ff == StRead), .wr_go(state_ff == StPush),
      .price(price_ff), .sum(long_sum), .full(long_full)
   );

   dmac_divider u_div (
      .clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp)
   );

   // A new item may start as soon as the sequencer is idle; a result that
   // still waits is held by the output register, not by the input.
   assign req_stall = (state_ff != StIdle);
   assign accept    = req_valid && !req_stall;
   assign in_range  = req_data.price_year >= first_year_ff &&
                      req_data.price_year <= last_year_ff;

   // Shared multiplier: the 80-bit left operand is consumed 32 bits at a
   // time against the price or a window, one partial product per step.
   assign mul_a = left_ff[31:0];
   always_comb begin
      unique case (state_ff)
         StMulL:  mul_b = 32'(lw_eff);
         StMulR:  mul_b = 32'(sw_eff);
         default: mul_b = price_ff;
      endcase
   end
   assign mul_p     = mul_a * mul_b;
   assign mul_sum   = acc_ff + (80'(mul_p) << (32 * step_ff));
   assign last_step = (state_ff == StMulL || state_ff == StMulR) ? 3'd2 : 3'd1;

   assign rel     = (left_ff > acc_ff) ? RelAbove :
                    (left_ff < acc_ff) ? RelBelow : RelEqual;
   assign prod_sh = acc_ff >> 16;
   assign prod48  = (prod_sh[79:48] != '0) ? Max48 : prod_sh[47:0];
   assign q_sat   = (div_rsp.quotient[63:48] != '0) ? Max48 :
                    div_rsp.quotient[47:0];

   always_comb begin
      state_in       = state_ff;
      cash_in        = cash_ff;
      shares_in      = shares_ff;
      trades_in      = trades_ff;
      prior_rel_in   = prior_rel_ff;
      prior_valid_in = prior_valid_ff;
      action_in      = action_ff;
      ready_in       = ready_ff;
      left_in        = left_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_in         = rsp_ff;
      div_req.start    = 1'b0;
      div_req.dividend = {cash_ff, 16'd0};
      div_req.divisor  = price_ff;
      add_tmp        = '0;

      unique case (state_ff)
         StIdle: begin
            if (accept && in_range) state_in = StRead;
         end
         StRead: state_in = StPush;
         // Window sums are visible the cycle after the push.
         StPush: state_in = StLoad;
         StLoad: begin
            action_in = ActNone;
            ready_in  = 1'b0;
            left_in   = 80'(short_sum);
            acc_in    = '0;
            step_in   = '0;
            state_in  = StMulL;
         end
         StMulL, StMulR, StSell, StValue: begin
            acc_in  = mul_sum;
            left_in = {32'd0, left_ff[79:32]};
            step_in = step_ff + 3'd1;
            if (step_ff == last_step) begin
               step_in = '0;
               if (state_ff == StMulL) begin
                  // The left product is parked aside; start the right one.
                  left_in  = 80'(long_sum);
                  acc_in   = '0;
                  state_in = StMulR;
               end else if (state_ff == StMulR) begin
                  ready_in = short_full && long_full;
                  if (short_full && long_full) begin
                     // Left product back in left_ff, right one in acc_ff.
                     left_in  = left_keep_ff;
                     state_in = StDecide;
                  end else begin
                     left_in  = {32'd0, shares_ff};
                     acc_in   = '0;
                     state_in = StValue;
                  end
               end else begin
                  if (state_ff == StSell) action_in = ActSell;
                  state_in = StOut;
               end
            end
         end
         StDecide: begin
            state_in = StValue;
            if (prior_valid_ff) begin
               if (prior_rel_ff != RelAbove && rel == RelAbove &&
                   cash_ff != '0) begin
                  if (price_ff != '0) begin
                     div_req.start = 1'b1;
                     state_in      = StDiv;
                  end
               end else if (prior_rel_ff != RelBelow && rel == RelBelow &&
                            shares_ff != '0) begin
                  state_in = StSell;
               end
            end
            prior_rel_in   = rel;
            prior_valid_in = 1'b1;
            left_in = {32'd0, shares_ff};
            acc_in  = '0;
            step_in = '0;
         end
         StDiv: begin
            if (div_rsp.done) begin
               add_tmp   = {1'b0, shares_ff} + {1'b0, q_sat};
               shares_in = add_tmp[48] ? Max48 : add_tmp[47:0];
               cash_in   = '0;
               action_in = ActBuy;
               if (trades_ff != 16'hFFFF) trades_in = trades_ff + 16'd1;
               left_in   = {32'd0, shares_in};
               state_in  = StValue;
            end
         end
         StOut: begin
            // A result still waiting in the output register holds this one.
            if (!(rsp_valid_ff && rsp_stall)) begin
               if (action_ff == ActSell) begin
                  add_tmp   = {1'b0, prod48} + {1'b0, cash_ff};
                  cash_in   = add_tmp[48] ? Max48 : add_tmp[47:0];
                  shares_in = '0;
                  if (trades_ff != 16'hFFFF) trades_in = trades_ff + 16'd1;
                  // Value is now cash alone.
                  rsp_in.portfolio_value = cash_in;
                  rsp_in.trade_total     = trades_in;
               end else begin
                  add_tmp = {1'b0, prod48} + {1'b0, cash_ff};
                  rsp_in.portfolio_value = add_tmp[48] ? Max48 : add_tmp[47:0];
                  rsp_in.trade_total     = trades_ff;
               end
               rsp_in.trade_action   = action_ff;
               rsp_in.averages_ready = ready_ff;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase

      // Register writes that touch the trading state.
      if (csr_write) begin
         unique case (csr_index)
            RegShortWindow: prior_valid_in = 1'b0;
            RegLongWindow:  prior_valid_in = 1'b0;
            RegStartingCash: begin
               cash_in   = csr_data;
               shares_in = '0;
            end
            default: ;
         endcase
      end
   end

   // The left product is kept aside while the right one accumulates.
   always_ff @(posedge clock) begin
      if (state_ff == StMulL && step_ff == last_step)
         left_keep_ff <= mul_sum;
   end

   always_ff @(posedge clock) begin
      if (accept) price_ff <= req_data.close_price;
      action_ff <= action_in;
      ready_ff  <= ready_in;
      left_ff   <= left_in;
      acc_ff    <= acc_in;
      step_ff   <= step_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= StIdle;
         rsp_valid_ff     <= 1'b0;
         short_window_ff  <= 7'd50;
         long_window_ff   <= 9'd200;
         first_year_ff    <= 14'd0;
         last_year_ff     <= 14'd9999;
         starting_cash_ff <= '0;
         cash_ff          <= '0;
         shares_ff        <= '0;
         trades_ff        <= '0;
         prior_rel_ff     <= RelEqual;
         prior_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         cash_ff        <= cash_in;
         shares_ff      <= shares_in;
         trades_ff      <= trades_in;
         prior_rel_ff   <= prior_rel_in;
         prior_valid_ff <= prior_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               RegShortWindow:  short_window_ff  <= csr_data[6:0];
               RegLongWindow:   long_window_ff   <= csr_data[8:0];
               RegFirstYear:    first_year_ff    <= csr_data[13:0];
               RegLastYear:     last_year_ff     <= csr_data[13:0];
               RegStartingCash: starting_cash_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A waiting result stays valid while rsp_stall is high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   // A buy always leaves no cash behind.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == StDiv && div_rsp.done |=> cash_ff == '0)
      else $error("cash left after buy");
   // The trade action is always one of the defined codes.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.trade_action == ActNone ||
                       rsp_ff.trade_action == ActBuy ||
                       rsp_ff.trade_action == ActSell)
      else $error("bad trade action");
   // A starting cash write loads the same value into the cash register.
   assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == RegStartingCash |=> cash_ff == starting_cash_ff)
      else $error("cash not loaded");
`endif

endmodule
